### src/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and helpers for the IMAP string token parser.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  localparam int LEN_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ATOM  = 4'd1,
    PH_NILW  = 4'd2,
    PH_QUOT  = 4'd3,
    PH_QESC  = 4'd4,
    PH_QEND  = 4'd5,
    PH_LDIG  = 4'd6,
    PH_LPLUS = 4'd7,
    PH_LCR   = 4'd8,
    PH_LLF   = 4'd9,
    PH_LDATA = 4'd10,
    PH_LEND  = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    RK_DATA = 2'd0,
    RK_DONE = 2'd1,
    RK_ERR  = 2'd2,
    RK_CONT = 2'd3
  } rk_t;

  localparam logic [1:0] TK_ASTRING = 2'd0;
  localparam logic [1:0] TK_NSTRING = 2'd1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // parser control state (literal count is kept apart, its width is a parameter)
  typedef struct packed {
    phase_t     phase;
    logic       digit_seen;
    logic       no_wait_seen;
    logic       nul_seen;
    logic [1:0] nil_index;
    logic       nil_mismatch;
  } ctl_t;

  typedef struct packed {
    rk_t        kind;
    logic [7:0] data_byte;
    logic [7:0] term_byte;
    logic       term_is_eof;
    logic       pushed_back;
    logic       is_nil;
  } res_t;

  function automatic logic atom_end(input logic eof, input logic [7:0] c);
    atom_end = eof || c == CH_SP || (c >= CH_TAB && c <= CH_CR) ||
               c == CH_LPAR || c == CH_RPAR || c == CH_DQ;
  endfunction

  function automatic res_t mk_data(input logic [7:0] c);
    res_t r;
    r = '0;
    r.kind = RK_DATA;
    r.data_byte = c;
    return r;
  endfunction

  // end of token: terminator fields only, pushback never on end of input
  function automatic res_t mk_fin(input rk_t k, input logic [7:0] c, input logic eof,
                                  input logic pb, input logic nil);
    res_t r;
    r = '0;
    r.kind = k;
    r.term_byte = eof ? CH_NUL : c;
    r.term_is_eof = eof;
    r.pushed_back = pb && !eof;
    r.is_nil = nil;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/itp_parse.sv
// ----------------------------------------------------------------------------
// itp_parse
// Next-state and result logic for one byte of the token parser.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_parse import itp_pkg::*; #(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  wire ctl_t                  ctl,
  input  wire logic [LEN_WIDTH-1:0]  cnt,
  input  wire logic [7:0]            byte_in,
  input  wire logic                  eof,
  input  wire logic [1:0]            token_kind,
  output ctl_t                       ctl_nxt,
  output logic [LEN_WIDTH-1:0]       cnt_nxt,
  output logic                       has_res,
  output res_t                       res
);

  logic [7:0]           c;
  logic [LEN_WIDTH+3:0] acc;      // count*10 + digit, with headroom for overflow
  logic [LEN_WIDTH-1:0] cnt_dec;

  assign c       = eof ? CH_NUL : byte_in;
  assign acc     = {1'b0, cnt, 3'b000} + {3'b000, cnt, 1'b0} +
                   {{(LEN_WIDTH+4-8){1'b0}}, c - CH_ZERO};
  assign cnt_dec = cnt - {{(LEN_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    ctl_nxt = ctl;
    cnt_nxt = cnt;
    has_res = 1'b0;
    res     = '0;
    case (ctl.phase)
      PH_IDLE: begin
        if (eof) begin
          has_res = 1'b1;
          res = mk_fin(RK_ERR, c, 1'b1, 1'b0, 1'b0);
        end else if (c inside {CH_SP, CH_LPAR, CH_RPAR, CH_CR, CH_LF}) begin
          has_res = 1'b1;
          res = mk_fin(RK_ERR, c, 1'b0, 1'b1, 1'b0);
        end else if (c == CH_DQ) begin
          ctl_nxt.phase = PH_QUOT;
        end else if (c == CH_LBRACE) begin
          ctl_nxt.phase        = PH_LDIG;
          ctl_nxt.digit_seen   = 1'b0;
          ctl_nxt.no_wait_seen = 1'b0;
          ctl_nxt.nul_seen     = 1'b0;
          cnt_nxt              = '0;
        end else if (token_kind == TK_ASTRING) begin
          has_res = 1'b1;
          if (atom_end(1'b0, c)) begin
            res = mk_fin(RK_DONE, c, 1'b0, 1'b0, 1'b0);
          end else begin
            ctl_nxt.phase = PH_ATOM;
            res = mk_data(c);
          end
        end else if (token_kind == TK_NSTRING && c == CH_N) begin
          ctl_nxt.phase        = PH_NILW;
          ctl_nxt.nil_index    = 2'd1;
          ctl_nxt.nil_mismatch = 1'b0;
        end else begin
          has_res = 1'b1;
          res = mk_fin(RK_ERR, c, 1'b0, 1'b1, 1'b0);
        end
      end
      PH_ATOM: begin
        has_res = 1'b1;
        if (atom_end(eof, c)) begin
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_DONE, c, eof, 1'b0, 1'b0);
        end else begin
          res = mk_data(c);
        end
      end
      PH_NILW: begin
        if (atom_end(eof, c)) begin
          has_res = 1'b1;
          ctl_nxt.phase = PH_IDLE;
          if (!ctl.nil_mismatch && ctl.nil_index == 2'd3) begin
            res = mk_fin(RK_DONE, c, eof, 1'b0, 1'b1);
          end else begin
            res = mk_fin(RK_ERR, c, eof, 1'b1, 1'b0);
          end
        end else if (ctl.nil_index == 2'd1 && c == CH_I) begin
          ctl_nxt.nil_index = 2'd2;
        end else if (ctl.nil_index == 2'd2 && c == CH_L) begin
          ctl_nxt.nil_index = 2'd3;
        end else begin
          ctl_nxt.nil_mismatch = 1'b1;
        end
      end
      PH_QUOT: begin
        if (eof) begin
          has_res = 1'b1;
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_ERR, c, 1'b1, 1'b0, 1'b0);
        end else if (c == CH_BSLASH) begin
          ctl_nxt.phase = PH_QESC;
        end else if (c == CH_DQ) begin
          ctl_nxt.phase = PH_QEND;
        end else if (c == CH_CR || c == CH_LF) begin
          has_res = 1'b1;
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_ERR, c, 1'b0, 1'b1, 1'b0);
        end else begin
          has_res = 1'b1;
          res = mk_data(c);
        end
      end
      PH_QESC: begin
        has_res = 1'b1;
        if (eof) begin
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_ERR, c, 1'b1, 1'b0, 1'b0);
        end else begin
          ctl_nxt.phase = PH_QUOT;
          res = mk_data(c);
        end
      end
      PH_QEND: begin
        has_res = 1'b1;
        ctl_nxt.phase = PH_IDLE;
        res = mk_fin(RK_DONE, c, eof, 1'b0, 1'b0);
      end
      PH_LDIG: begin
        if (!eof && c >= CH_ZERO && c <= CH_NINE) begin
          if (|acc[LEN_WIDTH+3:LEN_WIDTH]) begin
            // count no longer fits: digit is consumed
            has_res = 1'b1;
            ctl_nxt.phase = PH_IDLE;
            res = mk_fin(RK_ERR, c, 1'b0, 1'b0, 1'b0);
          end else begin
            cnt_nxt = acc[LEN_WIDTH-1:0];
            ctl_nxt.digit_seen = 1'b1;
          end
        end else if (!eof && c == CH_PLUS) begin
          ctl_nxt.no_wait_seen = 1'b1;
          ctl_nxt.phase = PH_LPLUS;
        end else if (!eof && c == CH_RBRACE && ctl.digit_seen) begin
          ctl_nxt.phase = PH_LCR;
        end else begin
          has_res = 1'b1;
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_ERR, c, eof, 1'b1, 1'b0);
        end
      end
      PH_LPLUS: begin
        if (!eof && c == CH_RBRACE && ctl.digit_seen) begin
          ctl_nxt.phase = PH_LCR;
        end else begin
          has_res = 1'b1;
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_ERR, c, eof, 1'b1, 1'b0);
        end
      end
      PH_LCR: begin
        if (!eof && c == CH_CR) begin
          ctl_nxt.phase = PH_LLF;
        end else begin
          has_res = 1'b1;
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_ERR, c, eof, 1'b1, 1'b0);
        end
      end
      PH_LLF: begin
        if (eof || c != CH_LF) begin
          has_res = 1'b1;
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_ERR, c, eof, 1'b1, 1'b0);
        end else begin
          ctl_nxt.phase = (cnt == '0) ? PH_LEND : PH_LDATA;
          if (!ctl.no_wait_seen) begin
            has_res = 1'b1;
            res = '0;
            res.kind = RK_CONT;
          end
        end
      end
      PH_LDATA: begin
        has_res = 1'b1;
        if (eof) begin
          ctl_nxt.phase = PH_IDLE;
          res = mk_fin(RK_ERR, c, 1'b1, 1'b0, 1'b0);
        end else begin
          if (c == CH_NUL) begin
            ctl_nxt.nul_seen = 1'b1;
          end
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            ctl_nxt.phase = PH_LEND;
          end
          res = mk_data(c);
        end
      end
      PH_LEND: begin
        has_res = 1'b1;
        ctl_nxt.phase = PH_IDLE;
        if (ctl.nul_seen) begin
          res = mk_fin(RK_ERR, c, eof, 1'b1, 1'b0);
        end else begin
          res = mk_fin(RK_DONE, c, eof, 1'b0, 1'b0);
        end
      end
      default: begin
        ctl_nxt.phase = PH_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/imap_string_token_parser.sv
// A transferred byte is held in the input register, then parsed into the result register, which drives out_valid.
// Throughput: one byte per cycle; the only stall is the result register held by out_stall.
// Bytes that produce no result (quote, brace, header digits, N-I-L) still pass through the input register.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to idle.
// ----------------------------------------------------------------------------
// imap_string_token_parser
// Byte-at-a-time parser for one IMAP astring / nstring / string token:
// atom, NIL, quoted string or {n}/{n+} literal, with content, done, error
// and continuation-request results.
// ----------------------------------------------------------------------------
`default_nettype none

module imap_string_token_parser import itp_pkg::*; #(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_at_eof,
  input  wire logic [1:0] in_token_kind,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_result_kind,
  output logic [7:0]      out_data_byte,
  output logic [7:0]      out_term_byte,
  output logic            out_term_is_eof,
  output logic            out_pushed_back,
  output logic            out_is_nil
);

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;
  logic       eof_r;
  logic [1:0] kind_r;

  // parser state
  ctl_t                 ctl_r, ctl_nxt;
  logic [LEN_WIDTH-1:0] cnt_r, cnt_nxt;

  // result register
  logic out_vld_r, out_vld_nxt;
  res_t res_r, res_nxt;
  logic has_res;

  logic in_xfer;
  logic advance;   // byte in the input register is parsed this cycle

  // The parsed byte moves on whenever the result register is free or is
  // being drained this cycle.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  itp_parse #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_parse (
    .ctl        (ctl_r),
    .cnt        (cnt_r),
    .byte_in    (byte_r),
    .eof        (eof_r),
    .token_kind (kind_r),
    .ctl_nxt    (ctl_nxt),
    .cnt_nxt    (cnt_nxt),
    .has_res    (has_res),
    .res        (res_nxt)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && has_res) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ctl_r     <= '{phase: PH_IDLE, default: '0};
      cnt_r     <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        ctl_r <= ctl_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_byte;
      eof_r  <= in_at_eof;
      kind_r <= in_token_kind;
    end
    if (advance && has_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_kind = res_r.kind;
  assign out_data_byte   = res_r.data_byte;
  assign out_term_byte   = res_r.term_byte;
  assign out_term_is_eof = res_r.term_is_eof;
  assign out_pushed_back = res_r.pushed_back;
  assign out_is_nil      = res_r.is_nil;

endmodule

`default_nettype wire

### src/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks for the token parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_checker import itp_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_result_kind,
  input wire logic [7:0] out_data_byte,
  input wire logic [7:0] out_term_byte,
  input wire logic       out_term_is_eof,
  input wire logic       out_pushed_back,
  input wire logic       out_is_nil
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_data_byte) && $stable(out_term_byte))
    else $error("result changed while stalled");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result after reset");

  // content and continuation carry no terminator information
  a_no_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_DATA || out_result_kind == RK_CONT) |->
      out_term_byte == 8'h00 && !out_term_is_eof && !out_pushed_back && !out_is_nil)
    else $error("terminator fields on content or continuation");

  a_nil_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_nil |-> out_result_kind == RK_DONE && !out_pushed_back)
    else $error("NIL flag outside a done result");

endmodule

bind imap_string_token_parser itp_checker u_itp_checker (.*);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// IMAP string token parser testbench
// Feeds byte streams (directed tokens, then random well-formed and broken
// tokens) through the parser under several sender/receiver idling mixes, and
// checks every result transfer field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
  import itp_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SYM_EOF     = 256;    // token_bytes entry meaning end of input
  localparam logic [1:0]  TK_STRING   = 2'd2;
  localparam logic [1:0]  TK_SPARE    = 2'd3;   // unused kind, parsed as string
  localparam logic [7:0]  CH_VT       = 8'h0B;
  localparam logic [7:0]  CH_FF       = 8'h0C;
  localparam logic [63:0] COUNT_MAX   = (64'd1 << LEN_WIDTH_DEF) - 64'd1;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte       = 8'h00;
  logic       in_at_eof     = 1'b0;
  logic [1:0] in_token_kind = 2'd0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_data_byte;
  logic [7:0] out_term_byte;
  logic       out_term_is_eof;
  logic       out_pushed_back;
  logic       out_is_nil;

  int unsigned cycle_count    = 0;
  int          mismatch_count = 0;
  int          bytes_sent     = 0;
  int          in_idle_pct    = 0;
  int          out_stall_pct  = 0;

  // bytes of the token under construction, SYM_EOF for end of input
  int token_bytes[$];

  imap_string_token_parser #(.LEN_WIDTH(LEN_WIDTH_DEF)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_at_eof       (in_at_eof),
    .in_token_kind   (in_token_kind),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_data_byte   (out_data_byte),
    .out_term_byte   (out_term_byte),
    .out_term_is_eof (out_term_is_eof),
    .out_pushed_back (out_pushed_back),
    .out_is_nil      (out_is_nil)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser predictor: its own copy of the token state, advanced once per
  // accepted byte transfer. Every result it predicts is queued in results_due.
  // --------------------------------------------------------------------------
  phase_t      parse_phase  = PH_IDLE;
  logic [1:0]  token_kind_q = 2'd0;
  logic [63:0] count_left   = '0;    // literal bytes still to come
  logic        have_digit   = 1'b0;
  logic        non_sync     = 1'b0;  // {n+} form, no go-ahead wanted
  logic        saw_nul      = 1'b0;
  logic [1:0]  nil_pos      = 2'd0;  // letters of NIL matched so far
  logic        nil_bad      = 1'b0;
  res_t        results_due[$];

  function automatic logic ends_atom(input logic eof, input logic [7:0] c);
    return eof || c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR || c == CH_LPAR || c == CH_RPAR || c == CH_DQ;
  endfunction

  task automatic due_content(input logic [7:0] c);
    res_t r;
    r = '0;
    r.kind = RK_DATA;
    r.data_byte = c;
    results_due.push_back(r);
  endtask

  // token over: the terminator is reported, pushback never applies to end of input
  task automatic due_end(input rk_t k, input logic [7:0] c, input logic eof,
                         input logic pb, input logic nil);
    res_t r;
    r = '0;
    r.kind = k;
    r.term_byte = eof ? 8'h00 : c;
    r.term_is_eof = eof;
    r.pushed_back = pb & ~eof;
    r.is_nil = nil;
    results_due.push_back(r);
    parse_phase = PH_IDLE;
  endtask

  task automatic parse_step(input logic [7:0] b, input logic eof, input logic [1:0] k);
    logic [7:0]  c;
    logic [63:0] digit;
    res_t        r;
    c = eof ? 8'h00 : b;
    case (parse_phase)
      PH_IDLE: begin
        token_kind_q = k;
        if (eof) due_end(RK_ERR, c, 1'b1, 1'b0, 1'b0);
        else if (c == CH_SP || c == CH_LPAR || c == CH_RPAR || c == CH_CR || c == CH_LF)
          due_end(RK_ERR, c, 1'b0, 1'b1, 1'b0);
        else if (c == CH_DQ) parse_phase = PH_QUOT;
        else if (c == CH_LBRACE) begin
          parse_phase = PH_LDIG;
          count_left = '0;
          have_digit = 1'b0;
          non_sync = 1'b0;
          saw_nul = 1'b0;
        end else if (token_kind_q == TK_ASTRING) begin
          // TAB, VT or FF first: an empty atom
          if (ends_atom(1'b0, c)) due_end(RK_DONE, c, 1'b0, 1'b0, 1'b0);
          else begin
            parse_phase = PH_ATOM;
            due_content(c);
          end
        end else if (token_kind_q == TK_NSTRING && c == CH_N) begin
          parse_phase = PH_NILW;
          nil_pos = 2'd1;
          nil_bad = 1'b0;
        end else due_end(RK_ERR, c, 1'b0, 1'b1, 1'b0);
      end
      PH_ATOM: begin
        if (ends_atom(eof, c)) due_end(RK_DONE, c, eof, 1'b0, 1'b0);
        else due_content(c);
      end
      PH_NILW: begin
        if (ends_atom(eof, c)) begin
          if (!nil_bad && nil_pos == 2'd3) due_end(RK_DONE, c, eof, 1'b0, 1'b1);
          else due_end(RK_ERR, c, eof, 1'b1, 1'b0);
        end else if (nil_pos == 2'd1 && c == CH_I) nil_pos = 2'd2;
        else if (nil_pos == 2'd2 && c == CH_L) nil_pos = 2'd3;
        else nil_bad = 1'b1;
      end
      PH_QUOT: begin
        if (eof) due_end(RK_ERR, c, 1'b1, 1'b0, 1'b0);
        else if (c == CH_BSLASH) parse_phase = PH_QESC;
        else if (c == CH_DQ) parse_phase = PH_QEND;
        else if (c == CH_CR || c == CH_LF) due_end(RK_ERR, c, 1'b0, 1'b1, 1'b0);
        else due_content(c);
      end
      PH_QESC: begin
        if (eof) due_end(RK_ERR, c, 1'b1, 1'b0, 1'b0);
        else begin
          parse_phase = PH_QUOT;
          due_content(c);
        end
      end
      PH_QEND: due_end(RK_DONE, c, eof, 1'b0, 1'b0);
      PH_LDIG: begin
        if (!eof && c >= CH_ZERO && c <= CH_NINE) begin
          digit = {56'd0, 8'(c - CH_ZERO)};
          // overflowing digit is consumed, so no pushback
          if (count_left > (COUNT_MAX - digit) / 10) due_end(RK_ERR, c, 1'b0, 1'b0, 1'b0);
          else begin
            count_left = count_left * 10 + digit;
            have_digit = 1'b1;
          end
        end else if (!eof && c == CH_PLUS) begin
          non_sync = 1'b1;
          parse_phase = PH_LPLUS;
        end else if (!eof && c == CH_RBRACE && have_digit) parse_phase = PH_LCR;
        else due_end(RK_ERR, c, eof, 1'b1, 1'b0);
      end
      PH_LPLUS: begin
        if (!eof && c == CH_RBRACE && have_digit) parse_phase = PH_LCR;
        else due_end(RK_ERR, c, eof, 1'b1, 1'b0);
      end
      PH_LCR: begin
        if (!eof && c == CH_CR) parse_phase = PH_LLF;
        else due_end(RK_ERR, c, eof, 1'b1, 1'b0);
      end
      PH_LLF: begin
        if (eof || c != CH_LF) due_end(RK_ERR, c, eof, 1'b1, 1'b0);
        else begin
          parse_phase = (count_left == '0) ? PH_LEND : PH_LDATA;
          if (!non_sync) begin
            r = '0;
            r.kind = RK_CONT;
            results_due.push_back(r);
          end
        end
      end
      PH_LDATA: begin
        if (eof) due_end(RK_ERR, c, 1'b1, 1'b0, 1'b0);
        else begin
          if (c == CH_NUL) saw_nul = 1'b1;
          count_left = (count_left - 64'd1) & COUNT_MAX;
          if (count_left == '0) parse_phase = PH_LEND;
          due_content(c);
        end
      end
      PH_LEND: begin
        // a NUL anywhere in the body turns the terminator into a pushed-back error
        if (saw_nul) due_end(RK_ERR, c, eof, 1'b1, 1'b0);
        else due_end(RK_DONE, c, eof, 1'b0, 1'b0);
      end
      default: parse_phase = PH_IDLE;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, and a check of every accepted result transfer
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("result kind %0d with nothing expected", out_result_kind));
      end else begin
        want = results_due.pop_front();
        if (out_result_kind != want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", out_result_kind, want.kind));
        if (out_data_byte != want.data_byte)
          flag_mismatch($sformatf("data %h, want %h", out_data_byte, want.data_byte));
        if (out_term_byte != want.term_byte)
          flag_mismatch($sformatf("term %h, want %h", out_term_byte, want.term_byte));
        if (out_term_is_eof != want.term_is_eof)
          flag_mismatch($sformatf("term_is_eof %b, want %b", out_term_is_eof, want.term_is_eof));
        if (out_pushed_back != want.pushed_back)
          flag_mismatch($sformatf("pushed_back %b, want %b", out_pushed_back, want.pushed_back));
        if (out_is_nil != want.is_nil)
          flag_mismatch($sformatf("is_nil %b, want %b", out_is_nil, want.is_nil));
      end
    end
  end

  // hard stop if the run hangs, e.g. a result that never turns up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------

  // One byte transfer. The idle gap (if any) lowers valid once; valid is
  // otherwise left high after acceptance so back-to-back bytes need no toggle.
  task automatic send_byte(input logic [7:0] b, input logic eof, input logic [1:0] k);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_at_eof     <= eof;
    in_token_kind <= k;
    do @(posedge clk); while (in_stall);
    parse_step(b, eof, k);
    bytes_sent++;
  endtask

  task automatic add_sym(input int v);
    token_bytes.push_back(v);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) token_bytes.push_back(int'(s[i]));
  endtask

  // Sends token_bytes; only the first byte carries the chosen kind, the rest
  // carry noise (the kind is meant to be ignored once a token has started).
  // In-byte is random on end-of-input transfers as it should be ignored too.
  task automatic send_token(input logic [1:0] k);
    logic [1:0] kind_now;
    for (int i = 0; i < token_bytes.size(); i++) begin
      kind_now = (i == 0) ? k : 2'($urandom_range(0, 3));
      if (token_bytes[i] == SYM_EOF) send_byte(8'($urandom_range(0, 255)), 1'b1, kind_now);
      else send_byte(8'(token_bytes[i]), 1'b0, kind_now);
    end
    token_bytes.delete();
  endtask

  // hold off until every predicted result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_terminator();
    case ($urandom_range(0, 9))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      5: return CH_LF;
      6: return CH_LPAR;
      7: return CH_RPAR;
      8: return CH_DQ;
      default: return SYM_EOF;
    endcase
  endfunction

  function automatic int pick_atom_byte(input bit first);
    int c;
    do c = $urandom_range(0, 255);
    while (ends_atom(1'b0, 8'(c)) || (first && c == CH_LBRACE));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  task automatic test_bad_start_bytes();
    add_sym(CH_SP);
    add_sym(CH_LPAR);
    add_sym(CH_RPAR);
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_sym(SYM_EOF);
    send_token(TK_STRING);
  endtask

  task automatic test_atoms();
    int enders[10];
    enders = '{CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR, CH_LF, CH_LPAR, CH_RPAR, CH_DQ, SYM_EOF};
    // one-letter atom closed by each terminator in turn
    foreach (enders[i]) begin
      add_sym(8'h41 + i);
      add_sym(enders[i]);
      send_token(TK_ASTRING);
    end
    // TAB, VT and FF as first byte give an empty atom
    for (int i = 1; i <= 3; i++) begin
      add_sym(enders[i]);
      send_token(TK_ASTRING);
    end
    add_sym(CH_NUL);
    add_sym(8'hFF);
    add_text("a1~");
    add_sym(8'h80);
    add_sym(CH_SP);
    send_token(TK_ASTRING);
    // plain string and the spare kind refuse an atom start
    add_sym(8'h61);
    send_token(TK_STRING);
    add_sym(8'h61);
    send_token(TK_SPARE);
  endtask

  task automatic test_nil_words();
    add_text("NIL ");
    send_token(TK_NSTRING);
    add_text("NIL");
    add_sym(SYM_EOF);
    send_token(TK_NSTRING);
    add_text("NILS)");
    send_token(TK_NSTRING);
    add_text("NI");
    add_sym(CH_CR);
    send_token(TK_NSTRING);
    add_text("N");
    add_sym(SYM_EOF);
    send_token(TK_NSTRING);
    add_text("x");
    send_token(TK_NSTRING);
    // NIL is only a word for nstring: here it is an ordinary atom
    add_text("NIL(");
    send_token(TK_ASTRING);
    add_text("\"x\" ");
    send_token(TK_NSTRING);
  endtask

  task automatic test_quoted_strings();
    add_text("\"a\\\"b\\\\c\" ");
    send_token(TK_STRING);
    // escaped CR is content, end of input after the close quote terminates
    add_sym(CH_DQ);
    add_sym(CH_BSLASH);
    add_sym(CH_CR);
    add_sym(CH_DQ);
    add_sym(SYM_EOF);
    send_token(TK_STRING);
    add_text("\"ab");
    add_sym(CH_CR);
    send_token(TK_ASTRING);
    add_sym(CH_DQ);
    add_sym(CH_LF);
    send_token(TK_NSTRING);
    add_text("\"ab");
    add_sym(SYM_EOF);
    send_token(TK_STRING);
    add_text("\"\\");
    add_sym(SYM_EOF);
    send_token(TK_STRING);
    add_text("\"\")");
    send_token(TK_SPARE);
  endtask

  task automatic test_literals();
    add_text("{3}");
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_text("a");
    add_sym(CH_NUL);
    add_text("b ");
    send_token(TK_STRING);
    add_text("{2+}");
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_text("xy)");
    send_token(TK_ASTRING);
    // zero counts go straight to the terminator
    add_text("{0}");
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_sym(CH_SP);
    send_token(TK_NSTRING);
    add_text("{0+}");
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_sym(SYM_EOF);
    send_token(TK_STRING);
    add_text("{02+}");
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_sym(SYM_EOF);
    send_token(TK_STRING);
    // broken headers
    add_text("{x");
    send_token(TK_STRING);
    add_text("{1++");
    send_token(TK_STRING);
    add_text("{}");
    send_token(TK_STRING);
    add_text("{+}");
    send_token(TK_STRING);
    add_text("{5}x");
    send_token(TK_STRING);
    add_text("{5}");
    add_sym(CH_CR);
    add_text("x");
    send_token(TK_STRING);
    add_text("{5");
    add_sym(SYM_EOF);
    send_token(TK_STRING);
    add_text("{1}");
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_sym(SYM_EOF);
    send_token(TK_STRING);
  endtask

  task automatic test_literal_counts();
    // largest count that fits; body cut short by end of input
    add_text("{4294967295}");
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_text("ab");
    add_sym(SYM_EOF);
    send_token(TK_STRING);
    add_text("{4294967295+}");
    add_sym(CH_CR);
    add_sym(CH_LF);
    add_sym(SYM_EOF);
    send_token(TK_STRING);
    // one past the top, and a count far beyond it
    add_text("{4294967296");
    send_token(TK_STRING);
    add_text("{9999999999");
    send_token(TK_STRING);
  endtask

  // --------------------------------------------------------------------------
  // Random tokens: mostly well-formed with random content, some noise
  // --------------------------------------------------------------------------
  task automatic send_random_token();
    int  c;
    int  n;
    bit  wait_for_go;
    // bring the parser back to idle so a new token really starts a token
    while (parse_phase != PH_IDLE)
      send_byte(8'($urandom_range(0, 255)), 1'b1, 2'($urandom_range(0, 3)));
    case ($urandom_range(0, 9))
      0, 1: begin
        add_sym(pick_atom_byte(1'b1));
        repeat ($urandom_range(0, 6)) add_sym(pick_atom_byte(1'b0));
        add_sym(pick_terminator());
        send_token(TK_ASTRING);
      end
      2: begin
        case ($urandom_range(0, 5))
          0: add_text("NI");
          1: add_text("NILE");
          2: add_text("NIX");
          3: begin
            add_sym(CH_N);
            repeat ($urandom_range(0, 3)) add_sym($urandom_range(8'h41, 8'h5A));
          end
          default: add_text("NIL");
        endcase
        add_sym(pick_terminator());
        send_token(TK_NSTRING);
      end
      3, 4: begin
        add_sym(CH_DQ);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 9) == 0) begin
            add_sym(CH_BSLASH);
            add_sym($urandom_range(0, 255));
          end else begin
            do c = $urandom_range(0, 255);
            while (c == CH_DQ || c == CH_BSLASH || c == CH_CR || c == CH_LF);
            add_sym(c);
          end
        end
        case ($urandom_range(0, 11))
          0: add_sym(CH_CR);
          1: add_sym(CH_LF);
          2: add_sym(SYM_EOF);
          default: begin
            add_sym(CH_DQ);
            add_sym(pick_terminator());
          end
        endcase
        send_token(2'($urandom_range(0, 3)));
      end
      5, 6, 7: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        wait_for_go = $urandom_range(0, 1);
        add_sym(CH_LBRACE);
        if ($urandom_range(0, 4) == 0) add_text("00");
        add_text($sformatf("%0d", n));
        if (!wait_for_go) add_sym(CH_PLUS);
        add_sym(CH_RBRACE);
        add_sym(CH_CR);
        add_sym(CH_LF);
        repeat (n) add_sym(($urandom_range(0, 11) == 0) ? 0 : $urandom_range(0, 255));
        add_sym(($urandom_range(0, 4) == 0) ? SYM_EOF : $urandom_range(0, 255));
        send_token(2'($urandom_range(0, 3)));
      end
      8: begin
        // broken header: up to two digits then one to three awkward bytes
        add_sym(CH_LBRACE);
        repeat ($urandom_range(0, 2)) add_sym($urandom_range(CH_ZERO, CH_NINE));
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 4))
            0: add_sym(CH_PLUS);
            1: add_sym(CH_RBRACE);
            2: add_sym(CH_CR);
            3: add_sym(SYM_EOF);
            default: add_sym($urandom_range(0, 255));
          endcase
        end
        send_token(2'($urandom_range(0, 3)));
      end
      default: begin
        // raw noise, end of input included
        repeat ($urandom_range(1, 4)) add_sym($urandom_range(0, SYM_EOF));
        send_token(2'($urandom_range(0, 3)));
      end
    endcase
  endtask

  // one idling mix per call; each ends with the sender held off until drained
  task automatic test_random_tokens(input int mix);
    int first_byte;
    case (mix)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 57; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 57; end
      default: begin in_idle_pct = 34; out_stall_pct = 34; end
    endcase
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < 100) send_random_token();
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_start_bytes();
    test_atoms();
    drain_results();
    test_nil_words();
    test_quoted_strings();
    test_literals();
    test_literal_counts();
    drain_results();
    for (int mix = 0; mix < 4; mix++) test_random_tokens(mix);
    // let any stray result show up before the final check
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
